// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/oamf_pkg.sv
// types, codes and defaults of the obstacle avoidance mode machine
`timescale 1ns / 1ps

package oamf_pkg;

    localparam int DIST_W     = 16;
    localparam int CNT_W      = 8;
    localparam int MODE_W     = 3;
    localparam int REASON_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_TRACK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DODGE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECOVER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ARRIVED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BLOCKED = 3'd4;

    // reason codes
    localparam logic [REASON_W-1:0] RSN_WAITING     = 4'd0;
    localparam logic [REASON_W-1:0] RSN_DONE        = 4'd1;
    localparam logic [REASON_W-1:0] RSN_ABORTED     = 4'd2;
    localparam logic [REASON_W-1:0] RSN_ARRIVED     = 4'd3;
    localparam logic [REASON_W-1:0] RSN_GOAL_BLOCK  = 4'd4;
    localparam logic [REASON_W-1:0] RSN_DODGE_START = 4'd5;
    localparam logic [REASON_W-1:0] RSN_CLEAR       = 4'd6;
    localparam logic [REASON_W-1:0] RSN_GAP_FOUND   = 4'd7;
    localparam logic [REASON_W-1:0] RSN_DODGING     = 4'd8;
    localparam logic [REASON_W-1:0] RSN_REAPPEARED  = 4'd9;
    localparam logic [REASON_W-1:0] RSN_CLEARED     = 4'd10;
    localparam logic [REASON_W-1:0] RSN_PUSHING     = 4'd11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DANGER       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_NEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_LEN = 3'd4;

    // register defaults
    localparam logic [DIST_W-1:0] DANGER_RST       = 16'd500;
    localparam logic [DIST_W-1:0] CLEAR_RST        = 16'd800;
    localparam logic [DIST_W-1:0] ARRIVE_RST       = 16'd200;
    localparam logic [DIST_W-1:0] GOAL_NEAR_RST    = 16'd550;
    localparam logic [CNT_W-1:0]  RECOVERY_LEN_RST = 8'd25;

    typedef struct packed {
        logic [DIST_W-1:0] danger_mm;
        logic [DIST_W-1:0] clear_mm;
        logic [DIST_W-1:0] arrive_mm;
        logic [DIST_W-1:0] goal_near_mm;
        logic [CNT_W-1:0]  recovery_len;
    } t_cfg;

    typedef struct packed {
        logic              sample_valid;
        logic [DIST_W-1:0] goal_dist_mm;
        logic [DIST_W-1:0] front_min_mm;
        logic [DIST_W-1:0] left_avg_mm;
        logic [DIST_W-1:0] right_avg_mm;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                turn_left;
        logic [REASON_W-1:0] reason_code;
    } t_result;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              left_flag;
        logic [CNT_W-1:0]  recover_count;
    } t_state;

endpackage

// File: src/oamf_ifs.sv
// handshake channel interfaces: sensor items, results and configuration writes
`timescale 1ns / 1ps

interface oamf_in_if import oamf_pkg::*;;
    logic              valid;
    logic              ready;
    logic              sample_valid;
    logic [DIST_W-1:0] goal_dist_mm;
    logic [DIST_W-1:0] front_min_mm;
    logic [DIST_W-1:0] left_avg_mm;
    logic [DIST_W-1:0] right_avg_mm;

    modport source (
        output valid, sample_valid, goal_dist_mm, front_min_mm, left_avg_mm, right_avg_mm,
        input  ready
    );
    modport sink (
        input  valid, sample_valid, goal_dist_mm, front_min_mm, left_avg_mm, right_avg_mm,
        output ready
    );
endinterface

interface oamf_out_if import oamf_pkg::*;;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic                turn_left;
    logic [REASON_W-1:0] reason_code;

    modport source (output valid, mode, turn_left, reason_code, input ready);
    modport sink (input valid, mode, turn_left, reason_code, output ready);
endinterface

interface oamf_cfg_if import oamf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/oamf_cfg_regs.sv
// configuration register file with its write channel
`timescale 1ns / 1ps

module oamf_cfg_regs import oamf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oamf_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DANGER:       n_cfg.danger_mm    = i_cfg.data;
                CFG_CLEAR:        n_cfg.clear_mm     = i_cfg.data;
                CFG_ARRIVE:       n_cfg.arrive_mm    = i_cfg.data;
                CFG_GOAL_NEAR:    n_cfg.goal_near_mm = i_cfg.data;
                CFG_RECOVERY_LEN: n_cfg.recovery_len = i_cfg.data[CNT_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.danger_mm    <= DANGER_RST;
            r_cfg.clear_mm     <= CLEAR_RST;
            r_cfg.arrive_mm    <= ARRIVE_RST;
            r_cfg.goal_near_mm <= GOAL_NEAR_RST;
            r_cfg.recovery_len <= RECOVERY_LEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/oamf_step.sv
// next mode, turn direction, countdown and reason for one sensor item
`timescale 1ns / 1ps

module oamf_step import oamf_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state_nxt,
    output t_result o_result
);

    logic             danger;
    logic             left_wider;
    logic [CNT_W-1:0] count_dec;
    t_state           state_nxt;
    logic [REASON_W-1:0] reason;

    assign danger     = i_item.front_min_mm < i_cfg.danger_mm;
    assign left_wider = i_item.left_avg_mm > i_item.right_avg_mm;
    // countdown saturates at zero
    assign count_dec  = (i_state.recover_count != '0) ?
                        i_state.recover_count - CNT_W'(1) : '0;

    always_comb begin
        state_nxt = i_state;
        reason    = RSN_WAITING;
        if (!i_item.sample_valid) begin
            reason = RSN_WAITING;
        end else if (i_state.mode == MODE_ARRIVED) begin
            reason = RSN_DONE;
        end else if (i_state.mode == MODE_BLOCKED) begin
            reason = RSN_ABORTED;
        end else if (i_item.goal_dist_mm < i_cfg.arrive_mm) begin
            state_nxt.mode = MODE_ARRIVED;
            reason         = RSN_ARRIVED;
        end else if (i_item.goal_dist_mm < i_cfg.goal_near_mm && danger) begin
            state_nxt.mode = MODE_BLOCKED;
            reason         = RSN_GOAL_BLOCK;
        end else begin
            unique case (i_state.mode)
                MODE_TRACK: begin
                    if (danger) begin
                        state_nxt.mode      = MODE_DODGE;
                        state_nxt.left_flag = left_wider;
                        reason              = RSN_DODGE_START;
                    end else begin
                        reason = RSN_CLEAR;
                    end
                end
                MODE_DODGE: begin
                    if (i_item.front_min_mm > i_cfg.clear_mm) begin
                        state_nxt.mode          = MODE_RECOVER;
                        state_nxt.recover_count = i_cfg.recovery_len;
                        reason                  = RSN_GAP_FOUND;
                    end else begin
                        reason = RSN_DODGING;
                    end
                end
                MODE_RECOVER: begin
                    state_nxt.recover_count = count_dec;
                    if (danger) begin
                        state_nxt.mode      = MODE_DODGE;
                        state_nxt.left_flag = left_wider;
                        reason              = RSN_REAPPEARED;
                    end else if (count_dec == '0) begin
                        state_nxt.mode = MODE_TRACK;
                        reason         = RSN_CLEARED;
                    end else begin
                        reason = RSN_PUSHING;
                    end
                end
                default: begin
                    state_nxt = i_state;
                    reason    = RSN_WAITING;
                end
            endcase
        end
    end

    assign o_state_nxt          = state_nxt;
    assign o_result.mode        = state_nxt.mode;
    assign o_result.turn_left   = state_nxt.left_flag;
    assign o_result.reason_code = reason;

endmodule

// File: src/obstacle_avoid_mode_fsm.sv
// obstacle avoidance mode machine: top level with input and result registers
//
// i_in carries one sensor summary per transfer (sample flag, goal distance,
// front minimum, left and right gaps, millimetres). o_out gives one result per
// item: mode, turn direction and reason code, in item order. i_cfg writes the
// five threshold registers by index and is always ready; the user must write
// it only while no item is in flight, which the block does not enforce. Indexes
// past the register list are ignored. An item is captured in the input register
// at its transfer and evaluated against the mode state into the result
// register, from which its result is offered. One item per cycle is sustained
// while results are taken: the input stage moves whenever the result register
// is empty or is being taken, so a stalled receiver backs up into i_in.ready
// after two items are held. Reset restores the register defaults, puts the mode
// in tracking with a right turn and a zero countdown, and empties both stages.
`timescale 1ns / 1ps

module obstacle_avoid_mode_fsm import oamf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oamf_in_if.sink   i_in,
    oamf_out_if.source o_out,
    oamf_cfg_if.sink  i_cfg
);

    t_cfg    cfg;
    t_item   in_item;
    t_state  state_nxt;
    t_result result;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_state  r_state;
    logic    advance;

    oamf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    oamf_step u_step (
        .i_cfg       (cfg),
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state_nxt (state_nxt),
        .o_result    (result)
    );

    assign in_item.sample_valid = i_in.sample_valid;
    assign in_item.goal_dist_mm = i_in.goal_dist_mm;
    assign in_item.front_min_mm = i_in.front_min_mm;
    assign in_item.left_avg_mm  = i_in.left_avg_mm;
    assign in_item.right_avg_mm = i_in.right_avg_mm;

    // the held item is evaluated once the result register has room
    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld          <= 1'b0;
            r_out_vld         <= 1'b0;
            r_state.mode      <= MODE_TRACK;
            r_state.left_flag <= 1'b0;
            r_state.recover_count <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= state_nxt;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.mode        = r_out.mode;
    assign o_out.turn_left   = r_out.turn_left;
    assign o_out.reason_code = r_out.reason_code;

endmodule

// File: src/oamf_checker.sv
// port-level checker for the mode machine, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oamf_checker import oamf_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [MODE_W-1:0]   i_out_mode,
    input logic                i_out_turn_left,
    input logic [REASON_W-1:0] i_out_reason_code
);

    logic out_xfer;
    logic out_stall;
    logic is_arrived;
    logic is_blocked;
    logic is_dodge;
    logic dodge_rsn;
    logic sticky_rsn;
    logic [MODE_W+REASON_W:0] out_word;
    logic r_seen_arrived;
    logic r_seen_blocked;

    assign out_xfer   = i_out_valid && i_out_ready;
    assign out_stall  = i_out_valid && !i_out_ready;
    assign is_arrived = i_out_mode == MODE_ARRIVED;
    assign is_blocked = i_out_mode == MODE_BLOCKED;
    assign is_dodge   = i_out_mode == MODE_DODGE;
    assign dodge_rsn  = i_out_reason_code == RSN_DODGE_START ||
                        i_out_reason_code == RSN_REAPPEARED ||
                        i_out_reason_code == RSN_DODGING;
    assign sticky_rsn = i_out_reason_code == RSN_DONE ||
                        i_out_reason_code == RSN_ABORTED;
    assign out_word   = {i_out_mode, i_out_turn_left, i_out_reason_code};

    // remember a delivered sticky mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_arrived <= 1'b0;
            r_seen_blocked <= 1'b0;
        end else if (out_xfer) begin
            if (i_out_mode == MODE_ARRIVED) begin
                r_seen_arrived <= 1'b1;
            end
            if (i_out_mode == MODE_BLOCKED) begin
                r_seen_blocked <= 1'b1;
            end
        end
    end

    `ASSERT_IMPLIES(a_arrived_sticky, i_clk, i_rst_n, out_xfer && r_seen_arrived, is_arrived)
    `ASSERT_IMPLIES(a_blocked_sticky, i_clk, i_rst_n, out_xfer && r_seen_blocked, is_blocked)
    `ASSERT_IMPLIES(a_dodge_reason, i_clk, i_rst_n, i_out_valid && dodge_rsn, is_dodge)
    `ASSERT_IMPLIES(a_sticky_reason, i_clk, i_rst_n, i_out_valid && sticky_rsn, is_arrived || is_blocked)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))

endmodule

bind obstacle_avoid_mode_fsm oamf_checker u_oamf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_mode        (o_out.mode),
    .i_out_turn_left   (o_out.turn_left),
    .i_out_reason_code (o_out.reason_code)
);

// File: tb/obstacle_avoid_mode_fsm_tb.sv
// self-checking testbench of the obstacle avoidance mode machine
`timescale 1ns / 1ps

module obstacle_avoid_mode_fsm_tb;
    import oamf_pkg::*;

    localparam int NUM_DIR      = 13;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int STICKY_ITEMS = 45;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_RECOVERY_LEN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    oamf_in_if  in_if ();
    oamf_out_if out_if ();
    oamf_cfg_if cfg_if ();

    obstacle_avoid_mode_fsm DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // mirror of the mode machine
    t_cfg    mdl_cfg;
    t_state  mdl_st;
    t_result pending_results[$];
    int      mismatch_count;
    bit      no_idle;
    int      rx_stall;

    // short directed sequence from reset, no sticky mode entered here
    t_dir_row dir_tbl [NUM_DIR] = '{
        '{'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{MODE_TRACK, 1'b0, RSN_WAITING}},
        '{'{1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1,
          '{MODE_TRACK, 1'b0, RSN_CLEAR}},
        '{'{1'b1, 16'd200, 16'd500, 16'hFFFF, 16'h0000}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{MODE_DODGE, 1'b0, RSN_DODGE_START}},
        '{'{1'b1, 16'hFFFF, 16'd800, 16'h1234, 16'h4321}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'd801, 16'h0000, 16'hFFFF}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'd500, 16'h00FF, 16'hFF00}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'd499, 16'd1, 16'd0}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'd550, 16'h0000, 16'd0, 16'd1}, 1'b0, '{'0, 1'b0, '0}},
        '{'{1'b1, 16'd549, 16'd801, 16'h5555, 16'hAAAA}, 1'b0, '{'0, 1'b0, '0}}
    };

    function automatic t_result advance_mode(t_item it);
        t_result r;
        logic    danger;
        danger = it.front_min_mm < mdl_cfg.danger_mm;
        r.reason_code = RSN_WAITING;
        if (!it.sample_valid) begin
            r.reason_code = RSN_WAITING;
        end else if (mdl_st.mode == MODE_ARRIVED) begin
            r.reason_code = RSN_DONE;
        end else if (mdl_st.mode == MODE_BLOCKED) begin
            r.reason_code = RSN_ABORTED;
        end else if (it.goal_dist_mm < mdl_cfg.arrive_mm) begin
            mdl_st.mode   = MODE_ARRIVED;
            r.reason_code = RSN_ARRIVED;
        end else if (it.goal_dist_mm < mdl_cfg.goal_near_mm && danger) begin
            mdl_st.mode   = MODE_BLOCKED;
            r.reason_code = RSN_GOAL_BLOCK;
        end else if (mdl_st.mode == MODE_TRACK) begin
            if (danger) begin
                mdl_st.mode      = MODE_DODGE;
                mdl_st.left_flag = it.left_avg_mm > it.right_avg_mm;
                r.reason_code    = RSN_DODGE_START;
            end else begin
                r.reason_code = RSN_CLEAR;
            end
        end else if (mdl_st.mode == MODE_DODGE) begin
            if (it.front_min_mm > mdl_cfg.clear_mm) begin
                mdl_st.mode          = MODE_RECOVER;
                mdl_st.recover_count = mdl_cfg.recovery_len;
                r.reason_code        = RSN_GAP_FOUND;
            end else begin
                r.reason_code = RSN_DODGING;
            end
        end else begin
            // countdown saturates at zero
            if (mdl_st.recover_count != '0)
                mdl_st.recover_count = mdl_st.recover_count - 1'b1;
            if (danger) begin
                mdl_st.mode      = MODE_DODGE;
                mdl_st.left_flag = it.left_avg_mm > it.right_avg_mm;
                r.reason_code    = RSN_REAPPEARED;
            end else if (mdl_st.recover_count == '0) begin
                mdl_st.mode   = MODE_TRACK;
                r.reason_code = RSN_CLEARED;
            end else begin
                r.reason_code = RSN_PUSHING;
            end
        end
        r.mode      = mdl_st.mode;
        r.turn_left = mdl_st.left_flag;
        return r;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(25, 5);
    endfunction

    // sensor summary; without sticky items the goal stays clear of arrival and blocking
    function automatic t_item gen_item(bit allow_sticky);
        t_item          it;
        logic [DIST_W-1:0] lo;
        logic [DIST_W-1:0] dgr;
        logic [DIST_W-1:0] clr;
        dgr = mdl_cfg.danger_mm;
        clr = mdl_cfg.clear_mm;
        it.sample_valid = ($urandom_range(9, 0) != 0);
        it.left_avg_mm  = DIST_W'($urandom());
        it.right_avg_mm = DIST_W'($urandom());
        case ($urandom_range(3, 0))
            0: it.right_avg_mm = it.left_avg_mm;
            1: it.right_avg_mm = it.left_avg_mm + 1'b1;
            2: it.right_avg_mm = it.left_avg_mm - 1'b1;
            default: ;
        endcase
        case ($urandom_range(7, 0))
            1: it.front_min_mm = (dgr != '0) ? dgr - 1'b1 : '0;
            2: it.front_min_mm = dgr;
            3: it.front_min_mm = clr;
            4: it.front_min_mm = (clr != DIST_MAX) ? clr + 1'b1 : clr;
            5: it.front_min_mm = (dgr != '0) ? DIST_W'($urandom_range(dgr - 1'b1, 0)) : '0;
            6: it.front_min_mm = DIST_W'($urandom_range(DIST_MAX, clr));
            default: it.front_min_mm = DIST_W'($urandom());
        endcase
        if (!it.sample_valid || (allow_sticky && $urandom_range(1, 0) == 1)) begin
            it.goal_dist_mm = DIST_W'($urandom());
        end else begin
            lo = mdl_cfg.arrive_mm;
            if (it.front_min_mm < dgr && mdl_cfg.goal_near_mm > lo)
                lo = mdl_cfg.goal_near_mm;
            if ($urandom_range(3, 0) == 0)
                it.goal_dist_mm = lo;
            else
                it.goal_dist_mm = DIST_W'($urandom_range(DIST_MAX, lo));
        end
        return it;
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_item(t_item it, bit typed, t_result res);
        t_result pred;
        int      gap;
        in_if.valid        <= 1'b1;
        in_if.sample_valid <= it.sample_valid;
        in_if.goal_dist_mm <= it.goal_dist_mm;
        in_if.front_min_mm <= it.front_min_mm;
        in_if.left_avg_mm  <= it.left_avg_mm;
        in_if.right_avg_mm <= it.right_avg_mm;
        do @(posedge i_clk); while (!in_if.ready);
        pred = advance_mode(it);
        pending_results.push_back(typed ? res : pred);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_DANGER:       mdl_cfg.danger_mm    = data;
            CFG_CLEAR:        mdl_cfg.clear_mm     = data;
            CFG_ARRIVE:       mdl_cfg.arrive_mm    = data;
            CFG_GOAL_NEAR:    mdl_cfg.goal_near_mm = data;
            CFG_RECOVERY_LEN: mdl_cfg.recovery_len = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // stop sending, let every result arrive, return at a falling edge
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_cfg(t_cfg c);
        logic [CFG_DATA_W-1:0] rec_word;
        rec_word = DIST_W'($urandom());
        rec_word[CNT_W-1:0] = c.recovery_len;
        cfg_write(CFG_DANGER, c.danger_mm);
        cfg_write(CFG_CLEAR, c.clear_mm);
        cfg_write(CFG_ARRIVE, c.arrive_mm);
        cfg_write(CFG_GOAL_NEAR, c.goal_near_mm);
        cfg_write(CFG_RECOVERY_LEN, rec_word);
        // unmapped index must leave every register alone
        cfg_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
                  CFG_DATA_W'($urandom()));
    endtask

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver with random stalls, changes only at the falling edge
    initial begin
        out_if.ready = 1'b0;
        rx_stall     = 0;
        forever begin
            @(negedge i_clk);
            if (rx_stall > 0) begin
                out_if.ready <= 1'b0;
                rx_stall--;
            end else begin
                out_if.ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: mode %0d turn_left %0d reason_code %0d",
                       out_if.mode, out_if.turn_left, out_if.reason_code);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.mode !== want.mode) begin
                    $error("mode: expected %0d, actual %0d", want.mode, out_if.mode);
                    mismatch_count++;
                end
                if (out_if.turn_left !== want.turn_left) begin
                    $error("turn_left: expected %0d, actual %0d",
                           want.turn_left, out_if.turn_left);
                    mismatch_count++;
                end
                if (out_if.reason_code !== want.reason_code) begin
                    $error("reason_code: expected %0d, actual %0d",
                           want.reason_code, out_if.reason_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_cfg c;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.sample_valid  = 1'b0;
        in_if.goal_dist_mm  = '0;
        in_if.front_min_mm  = '0;
        in_if.left_avg_mm   = '0;
        in_if.right_avg_mm  = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        mismatch_count      = 0;
        no_idle             = 1'b0;
        mdl_cfg.danger_mm    = DANGER_RST;
        mdl_cfg.clear_mm     = CLEAR_RST;
        mdl_cfg.arrive_mm    = ARRIVE_RST;
        mdl_cfg.goal_near_mm = GOAL_NEAR_RST;
        mdl_cfg.recovery_len = RECOVERY_LEN_RST;
        mdl_st.mode          = MODE_TRACK;
        mdl_st.left_flag     = 1'b0;
        mdl_st.recover_count = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
            send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].res);
        drain();

        for (int p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: c = '{danger_mm: '0, clear_mm: '0, arrive_mm: '0,
                         goal_near_mm: '0, recovery_len: 8'd1};
                2: c = '{danger_mm: DIST_MAX, clear_mm: DIST_MAX, arrive_mm: '0,
                         goal_near_mm: DIST_MAX, recovery_len: 8'd255};
                3: c = '{danger_mm: DANGER_RST, clear_mm: CLEAR_RST, arrive_mm: ARRIVE_RST,
                         goal_near_mm: GOAL_NEAR_RST, recovery_len: 8'd1};
                4: begin
                    c.danger_mm    = DIST_W'($urandom());
                    c.clear_mm     = DIST_W'($urandom());
                    c.arrive_mm    = DIST_W'($urandom());
                    c.goal_near_mm = DIST_W'($urandom());
                    c.recovery_len = CNT_W'($urandom_range(255, 1));
                end
                default: begin
                    c.danger_mm    = DIST_W'($urandom_range(4000, 0));
                    c.clear_mm     = c.danger_mm + DIST_W'($urandom_range(2000, 0));
                    c.arrive_mm    = DIST_W'($urandom_range(1000, 0));
                    c.goal_near_mm = DIST_W'($urandom_range(3000, 0));
                    c.recovery_len = CNT_W'($urandom_range(6, 1));
                end
            endcase
            load_cfg(c);
            no_idle = ($urandom_range(3, 0) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // hold the sender until the results catch up
                if (k == PHASE_ITEMS / 2)
                    drain();
                send_item(gen_item(1'b0), 1'b0, '0);
            end
            drain();
        end

        // last phase may land in a sticky mode, which only reset leaves
        c.danger_mm    = DIST_W'($urandom_range(1000, 200));
        c.clear_mm     = c.danger_mm + DIST_W'($urandom_range(600, 0));
        c.arrive_mm    = ($urandom_range(1, 0) == 1) ? DIST_MAX
                                                     : DIST_W'($urandom_range(600, 100));
        c.goal_near_mm = DIST_W'($urandom_range(2000, 0));
        c.recovery_len = CNT_W'($urandom_range(4, 1));
        load_cfg(c);
        no_idle = 1'b0;
        for (int k = 0; k < STICKY_ITEMS; k++)
            send_item(gen_item(1'b1), 1'b0, '0);
        drain();
        repeat (5) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
